FILE: design/binary_decision_tree_classifier_assert.svh
// assertion macros for the binary decision tree classifier
// expects aclk and aresetn in the scope where a macro is used
`ifndef BINARY_DECISION_TREE_CLASSIFIER_ASSERT_SVH
`define BINARY_DECISION_TREE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define BDTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bdtc assertion failed");

// next-cycle implication, checked out of reset
`define BDTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bdtc assertion failed");

`else

`define BDTC_ASSERT_IMP(label, ante, cons)
`define BDTC_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: design/bdtc_pkg.sv
// shared types and constants of the binary decision tree classifier
// no dependencies
`default_nettype none

package bdtc_pkg;

    // tree and example sizes
    localparam int MAX_NODES    = 63;
    localparam int NUM_FEATURES = 64;
    localparam int TABLE_DEPTH  = 64;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int FEAT_W       = 64;
    localparam int STEP_W       = $clog2(MAX_NODES + 1);

    // features at or beyond NUM_FEATURES read as zero
    localparam logic [FEAT_W-1:0] FEAT_MASK =
        (NUM_FEATURES >= FEAT_W) ? {FEAT_W{1'b1}}
                                 : ((FEAT_W'(1) << NUM_FEATURES) - FEAT_W'(1));

    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_NODES);
    localparam logic [IDX_W-1:0]  NODE_ROOT  = IDX_W'(1);

    // item modes
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  node_index;
        logic              node_is_leaf;
        logic              node_class;
        logic [IDX_W-1:0]  node_feature;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic [FEAT_W-1:0] example_features;
    } in_beat_t;

    typedef struct packed {
        logic predicted_class;
        logic fault;
    } out_beat_t;

    // stored node entry (written flag kept apart)
    typedef struct packed {
        logic             leaf;
        logic             cls;
        logic [IDX_W-1:0] feature;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic terminal;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: design/bdtc_ctrl.sv
// controller of the binary decision tree classifier: idle / walk sequencing
// depends on bdtc_pkg
`default_nettype none

module bdtc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_mode,
    output logic                  s_ready,
    input  wire bdtc_pkg::status_t status,
    output bdtc_pkg::cmd_t        cmd
);
    import bdtc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_mode == MODE_CLASSIFY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_WALK;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                if (status.terminal) begin
                    // hold the finished walk until the result register is free
                    if (status.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bdtc_datapath.sv
// datapath of the binary decision tree classifier: node memory, walk
// registers and result register; depends on bdtc_pkg
`default_nettype none

module bdtc_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bdtc_pkg::in_beat_t s_payload,
    input  wire bdtc_pkg::cmd_t     cmd,
    output bdtc_pkg::status_t       status,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bdtc_pkg::out_beat_t     m_payload
);
    import bdtc_pkg::*;

    node_t               node_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] node_valid_reg;

    node_t               rd_node_reg;
    logic                rd_valid_reg;
    logic [FEAT_W-1:0]   feats_reg;
    logic [STEP_W-1:0]   steps_reg;
    logic                m_valid_reg;
    out_beat_t           result_reg;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                feat_bit;
    logic [IDX_W-1:0]    next_node;
    node_t               wr_node;
    out_beat_t           result_next;

    // entry built from a write beat
    always_comb begin
        wr_node.leaf    = s_payload.node_is_leaf;
        wr_node.cls     = s_payload.node_class;
        wr_node.feature = s_payload.node_feature;
        wr_node.left    = s_payload.left_child;
        wr_node.right   = s_payload.right_child;
    end

    // branch on the tested feature bit
    assign feat_bit  = feats_reg[rd_node_reg.feature];
    assign next_node = feat_bit ? rd_node_reg.right : rd_node_reg.left;

    // read the root on start, the chosen child on each step
    assign rd_en   = cmd.start | cmd.step;
    assign rd_addr = cmd.start ? NODE_ROOT : next_node;

    // walk ends at an unwritten node, a leaf or the step limit
    assign status.terminal = !rd_valid_reg || rd_node_reg.leaf || (steps_reg >= STEP_LIMIT);
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        result_next.fault           = !rd_valid_reg || !rd_node_reg.leaf;
        result_next.predicted_class = (rd_valid_reg && rd_node_reg.leaf) ? rd_node_reg.cls
                                                                           : 1'b0;
    end

    // node memory write port
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            node_mem[s_payload.node_index] <= wr_node;
        end
    end

    // node memory registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_node_reg <= node_mem[rd_addr];
        end
    end

    // written flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (cmd.write) begin
                node_valid_reg[s_payload.node_index] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= node_valid_reg[rd_addr];
            end
        end
    end

    // example and edge count of the walk in progress
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            feats_reg <= s_payload.example_features & FEAT_MASK;
            steps_reg <= '0;
        end else if (cmd.step) begin
            steps_reg <= steps_reg + STEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result_reg <= result_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

endmodule

`default_nettype wire

FILE: design/binary_decision_tree_classifier.sv
// Binary decision tree classifier. A write beat (mode 0) stores one node in a
// 64-entry table. A classify beat (mode 1) walks the tree from node 1, one
// node per cycle through the registered read port of the node memory; no new
// beat is taken until the walk has ended and its result is registered. The
// result sits in an output register, so the next beat is accepted while it
// waits. A walk ending at an unwritten node or inner node at the step limit
// gives fault set and class 0. Written flags clear at reset; no clearing pass.
// Depends on bdtc_pkg, bdtc_ctrl, bdtc_datapath and the assertion header.
`default_nettype none
`include "binary_decision_tree_classifier_assert.svh"

module binary_decision_tree_classifier (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bdtc_pkg::in_beat_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bdtc_pkg::out_beat_t      m_payload
);
    import bdtc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    bdtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_payload.mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, walk and result
    bdtc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // a classify beat blocks the input while its walk runs
    `BDTC_ASSERT_NXT(a_walk_blocks_input, s_valid && s_ready && (s_payload.mode == MODE_CLASSIFY), !s_ready)
    // a waiting result is never overwritten
    `BDTC_ASSERT_IMP(a_no_result_overwrite, cmd.finish, !m_valid || m_ready)
    // a result appears only from a finished walk
    `BDTC_ASSERT_IMP(a_result_from_walk, $rose(m_valid), $past(cmd.finish))

endmodule

`default_nettype wire

FILE: tb/tb_binary_decision_tree_classifier.sv
// self-checking testbench for binary_decision_tree_classifier: node writes and tree walks
// drives valid/ready beats with random gaps and checks results against a node table mirror
// depends on bdtc_pkg and the classifier RTL
`timescale 1ns / 100ps

module tb_binary_decision_tree_classifier;
    import bdtc_pkg::*;

    localparam int TARGET_ITEMS = 1750;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 80;

    typedef logic [IDX_W-1:0] idx_q_t[$];

    // mirror of the node table and the verdicts still owed by the block
    class tree_mirror;
        node_t     nodes[TABLE_DEPTH];
        bit        written[TABLE_DEPTH];
        out_beat_t verdicts_due[$];
        int        errors;
        int        n_writes;
        int        n_walks;
        int        n_faults;
        int        n_checked;
        int        deepest;

        // follow the tree from the root for one example
        function out_beat_t walk_tree(logic [FEAT_W-1:0] feats);
            logic [IDX_W-1:0]  cur;
            logic [FEAT_W-1:0] live;
            out_beat_t         res;
            cur  = NODE_ROOT;
            live = feats & FEAT_MASK;
            res.predicted_class = 1'b0;
            res.fault = 1'b1;
            for (int steps = 0; steps <= MAX_NODES; steps++) begin
                if (steps > deepest) deepest = steps;
                if (!written[cur]) return res;
                if (nodes[cur].leaf) begin
                    res.predicted_class = nodes[cur].cls;
                    res.fault = 1'b0;
                    return res;
                end
                // inner node still reached after the last allowed edge
                if (steps == MAX_NODES) return res;
                cur = live[nodes[cur].feature] ? nodes[cur].right : nodes[cur].left;
            end
            return res;
        endfunction

        function void note_beat(in_beat_t beat);
            out_beat_t res;
            if (beat.mode == MODE_WRITE) begin
                written[beat.node_index] = 1'b1;
                nodes[beat.node_index].leaf    = beat.node_is_leaf;
                nodes[beat.node_index].cls     = beat.node_class;
                nodes[beat.node_index].feature = beat.node_feature;
                nodes[beat.node_index].left    = beat.left_child;
                nodes[beat.node_index].right   = beat.right_child;
                n_writes++;
            end else begin
                res = walk_tree(beat.example_features);
                if (res.fault) n_faults++;
                verdicts_due.push_back(res);
                n_walks++;
            end
        endfunction

        function void check_verdict(out_beat_t got);
            out_beat_t want;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, got class=%0b fault=%0b",
                         $time, got.predicted_class, got.fault);
                return;
            end
            want = verdicts_due.pop_front();
            n_checked++;
            if (got.predicted_class !== want.predicted_class) begin
                errors++;
                $display("%0t: predicted_class expected %0b actual %0b",
                         $time, want.predicted_class, got.predicted_class);
            end
            if (got.fault !== want.fault) begin
                errors++;
                $display("%0t: fault expected %0b actual %0b", $time, want.fault, got.fault);
            end
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_payload;

    tree_mirror mirror = new();
    int items_sent   = 0;
    int s_calm       = 0;
    int m_calm       = 0;
    int quiet_cycles = 0;

    binary_decision_tree_classifier DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle cycles before the next beat, with stretches of back-to-back beats
    function automatic int next_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
        return $urandom_range(0, 18);
    endfunction

    // every table index except the root, in random order
    function automatic idx_q_t spare_nodes();
        idx_q_t           pool;
        logic [IDX_W-1:0] tmp;
        int               j;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i != NODE_ROOT) pool.push_back(IDX_W'(i));
        end
        for (int i = pool.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        return pool;
    endfunction

    function automatic logic [FEAT_W-1:0] rand_features();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return FEAT_W'(1) << $urandom_range(0, FEAT_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present one beat and hold it until accepted
    task automatic send_beat(input in_beat_t beat);
        int gap;
        gap = next_gap(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        mirror.note_beat(beat);
        items_sent++;
    endtask

    // node write, example field carries noise
    task automatic put_node(input logic [IDX_W-1:0] idx, input logic leaf, input logic cls,
                            input logic [IDX_W-1:0] feat, input logic [IDX_W-1:0] lc,
                            input logic [IDX_W-1:0] rc);
        in_beat_t beat;
        beat.mode             = MODE_WRITE;
        beat.node_index       = idx;
        beat.node_is_leaf     = leaf;
        beat.node_class       = cls;
        beat.node_feature     = feat;
        beat.left_child       = lc;
        beat.right_child      = rc;
        beat.example_features = {$urandom, $urandom};
        send_beat(beat);
    endtask

    // classify beat, node fields carry noise
    task automatic put_example(input logic [FEAT_W-1:0] feats);
        in_beat_t    beat;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        beat  = noise[$bits(in_beat_t)-1:0];
        beat.mode             = MODE_CLASSIFY;
        beat.example_features = feats;
        send_beat(beat);
    endtask

    // hold off the sender until every owed verdict is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mirror.verdicts_due.size() > 0) @(posedge aclk);
    endtask

    // random tree built breadth first from the root
    task automatic grow_tree(input int max_inner);
        idx_q_t           pool;
        idx_q_t           open_q;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] lc;
        logic [IDX_W-1:0] rc;
        int               inner_cnt;
        pool = spare_nodes();
        open_q.push_back(NODE_ROOT);
        inner_cnt = 0;
        while (open_q.size() > 0) begin
            cur = open_q.pop_front();
            if (pool.size() < 2 || inner_cnt >= max_inner ||
                (cur != NODE_ROOT && $urandom_range(0, 99) < 35)) begin
                put_node(cur, 1'b1, 1'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                         IDX_W'($urandom));
            end else begin
                lc = pool.pop_front();
                rc = pool.pop_front();
                put_node(cur, 1'b0, 1'($urandom), IDX_W'($urandom), lc, rc);
                inner_cnt++;
                // now and then a child is left pointing at a stale or empty entry
                if ($urandom_range(0, 19) != 0) open_q.push_back(lc);
                if ($urandom_range(0, 19) != 0) open_q.push_back(rc);
            end
        end
    endtask

    // one long path from the root, ending in a leaf or looping back
    task automatic grow_chain(input int edges, input bit close_loop);
        idx_q_t           pool;
        idx_q_t           path;
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] other;
        pool = spare_nodes();
        path.push_back(NODE_ROOT);
        for (int i = 0; i < edges; i++) path.push_back(pool.pop_front());
        for (int i = 0; i < edges; i++) begin
            nxt   = path[i + 1];
            other = ($urandom_range(0, 1) == 0) ? nxt : IDX_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                put_node(path[i], 1'b0, 1'($urandom), IDX_W'($urandom), nxt, other);
            else
                put_node(path[i], 1'b0, 1'($urandom), IDX_W'($urandom), other, nxt);
        end
        if (close_loop)
            put_node(path[edges], 1'b0, 1'($urandom), IDX_W'($urandom),
                     path[$urandom_range(0, edges)], path[$urandom_range(0, edges)]);
        else
            put_node(path[edges], 1'b1, 1'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                     IDX_W'($urandom));
    endtask

    // result side with random stalls
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = next_gap(m_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            mirror.check_verdict(m_payload);
        end
    end

    // cycles in which no beat moved on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin
        int kind;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: root never written
        put_example('0);
        // root as leaf with all spare fields at max
        put_node(NODE_ROOT, 1'b1, 1'b1, '1, '1, '1);
        put_example('1);
        // entry zero reached through a child, top feature bit tested
        put_node('0, 1'b1, 1'b1, '0, '0, '0);
        put_node('1, 1'b1, 1'b0, '0, '0, '0);
        put_node(NODE_ROOT, 1'b0, 1'b1, IDX_W'(FEAT_W - 1), '0, '1);
        put_example('0);
        put_example('1);
        put_example({1'b1, {(FEAT_W - 1){1'b0}}});
        put_example({1'b0, {(FEAT_W - 1){1'b1}}});
        // rewriting a leaf replaces its class
        put_node('1, 1'b1, 1'b1, '1, '1, '1);
        put_example('1);
        // left child never written, right child loops onto the root
        put_node(NODE_ROOT, 1'b0, 1'b0, '0, IDX_W'(2), NODE_ROOT);
        put_example('0);
        put_example(FEAT_W'(1));
        put_node(IDX_W'(2), 1'b1, 1'b0, '1, '1, '1);
        put_example('0);
        put_example({$urandom, $urandom} & ~FEAT_W'(1));
        drain_results();

        // random phases
        while (items_sent < TARGET_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                grow_tree(($urandom_range(0, 4) == 0) ? $urandom_range(16, 31)
                                                      : $urandom_range(1, 15));
                repeat ($urandom_range(30, 100)) put_example(rand_features());
            end else if (kind < 8) begin
                grow_chain(($urandom_range(0, 3) == 0) ? MAX_NODES
                                                       : $urandom_range(1, MAX_NODES),
                           $urandom_range(0, 3) == 0);
                repeat ($urandom_range(8, 24)) put_example(rand_features());
            end else begin
                // noise: stray writes mixed with walks
                repeat ($urandom_range(10, 30)) begin
                    if ($urandom_range(0, 9) < 4)
                        put_node(IDX_W'($urandom), 1'($urandom), 1'($urandom),
                                 IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
                    else
                        put_example(rand_features());
                end
            end
            if ($urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mirror.verdicts_due.size() > 0) begin
            mirror.errors++;
            $display("%0t: %0d expected results never arrived, expected %0d actual 0",
                     $time, mirror.verdicts_due.size(), mirror.verdicts_due.size());
        end

        $display("covered %0d node writes and %0d walks, %0d of them faulting",
                 mirror.n_writes, mirror.n_walks, mirror.n_faults);
        $display("checked %0d result beats, deepest walk %0d edges, %0d mismatches",
                 mirror.n_checked, mirror.deepest, mirror.errors);
        if (mirror.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
